>>> rtl/core/rpn_pkg.sv
package rpn_pkg;

   // Byte codes that the path rules look at.
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DEL    = 8'h7F;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_COLON  = 8'h3A;
   localparam logic [7:0] CHR_DOT    = 8'h2E;
   localparam logic [7:0] CHR_NONE   = 8'h00;

   // Most dots a component may hold back before it turns ordinary.
   localparam logic [1:0] MAX_HELD_DOTS = 2'd2;

   // Fixed result slots of one burst, in output order.
   localparam int SLOT_SEP     = 0;
   localparam int SLOT_DOT1    = 1;
   localparam int SLOT_DOT2    = 2;
   localparam int SLOT_BYTE    = 3;
   localparam int SLOT_VERDICT = 4;
   localparam int NUM_SLOTS    = 5;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   // Results caused by one input beat.
   typedef struct packed {
      slot_mask_type mask;
      logic [7:0]    byte_val;
      logic          path_ok;
   } burst_type;

endpackage

>>> rtl/core/rpn_step.sv
module rpn_step
   import rpn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] chr,
   input  logic       has_char,
   input  logic       last,
   output burst_type  burst
);

   logic       seen_byte_ff, seen_byte_in;
   logic       sep_pending_ff, sep_pending_in;
   logic       in_component_ff, in_component_in;
   logic       only_dots_ff, only_dots_in;
   logic [1:0] held_dots_ff, held_dots_in;
   logic       prev_was_sep_ff, prev_was_sep_in;
   logic       failed_ff, failed_in;
   logic       is_sep;
   logic       is_bad;

   assign is_sep = (chr == CHR_SLASH) || (chr == CHR_BSLASH);
   assign is_bad = (chr < CHR_SPACE) || (chr == CHR_DEL) || (chr == CHR_COLON);

   // Working values start from the stored state and are updated in model order.
   always_comb begin
      seen_byte_in    = seen_byte_ff;
      sep_pending_in  = sep_pending_ff;
      in_component_in = in_component_ff;
      only_dots_in    = only_dots_ff;
      held_dots_in    = held_dots_ff;
      prev_was_sep_in = prev_was_sep_ff;
      failed_in       = failed_ff;
      burst.mask      = '0;
      burst.byte_val  = chr;
      burst.path_ok   = 1'b0;

      if (has_char) begin
         if (failed_ff) begin
            failed_in = 1'b1;
         end else if (is_bad) begin
            failed_in = 1'b1;
         end else if (is_sep) begin
            if (!seen_byte_ff) begin
               failed_in = 1'b1;
            end else if (in_component_ff) begin
               if (only_dots_ff && (held_dots_ff != 2'd0)) begin
                  failed_in = 1'b1;
               end else begin
                  in_component_in = 1'b0;
                  sep_pending_in  = 1'b1;
               end
            end
            prev_was_sep_in = 1'b1;
         end else begin
            if (!in_component_ff) begin
               in_component_in = 1'b1;
               only_dots_in    = 1'b1;
               held_dots_in    = 2'd0;
            end
            if (only_dots_in) begin
               if ((chr == CHR_DOT) && (held_dots_in < MAX_HELD_DOTS)) begin
                  held_dots_in = held_dots_in + 2'd1;
               end else begin
                  // Flush the owed separator and held dots ahead of this byte.
                  burst.mask[SLOT_SEP]  = sep_pending_in;
                  burst.mask[SLOT_DOT1] = (held_dots_in != 2'd0);
                  burst.mask[SLOT_DOT2] = (held_dots_in == MAX_HELD_DOTS);
                  burst.mask[SLOT_BYTE] = 1'b1;
                  sep_pending_in        = 1'b0;
                  held_dots_in          = 2'd0;
                  only_dots_in          = 1'b0;
               end
            end else begin
               burst.mask[SLOT_BYTE] = 1'b1;
            end
            prev_was_sep_in = 1'b0;
         end
         seen_byte_in = 1'b1;
      end

      if (last) begin
         burst.mask[SLOT_VERDICT] = 1'b1;
         burst.path_ok = !failed_in && seen_byte_in && !prev_was_sep_in &&
                         in_component_in && !(only_dots_in && (held_dots_in != 2'd0));
         seen_byte_in    = 1'b0;
         sep_pending_in  = 1'b0;
         in_component_in = 1'b0;
         only_dots_in    = 1'b1;
         held_dots_in    = 2'd0;
         prev_was_sep_in = 1'b0;
         failed_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_byte_ff    <= 1'b0;
         sep_pending_ff  <= 1'b0;
         in_component_ff <= 1'b0;
         only_dots_ff    <= 1'b1;
         held_dots_ff    <= 2'd0;
         prev_was_sep_ff <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (accept) begin
         seen_byte_ff    <= seen_byte_in;
         sep_pending_ff  <= sep_pending_in;
         in_component_ff <= in_component_in;
         only_dots_ff    <= only_dots_in;
         held_dots_ff    <= held_dots_in;
         prev_was_sep_ff <= prev_was_sep_in;
         failed_ff       <= failed_in;
      end
   end

endmodule

>>> rtl/core/rpn_burst.sv
module rpn_burst
   import rpn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  burst_type  burst,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_char,
   output logic       is_char,
   output logic       path_ok,
   output logic       end_of_path
);

   slot_mask_type mask_ff, mask_in;
   logic [7:0]    byte_ff;
   logic          ok_ff;
   slot_mask_type head;
   slot_mask_type rest;
   logic          fire;

   // The lowest pending slot is the result on the port.
   assign head      = mask_ff & (~mask_ff + slot_mask_type'(1));
   assign rest      = mask_ff & ~head;
   assign out_valid = (mask_ff != '0);
   assign fire      = out_valid && out_ready;
   assign can_load  = !out_valid || (fire && (rest == '0));

   assign is_char     = !head[SLOT_VERDICT];
   assign end_of_path = head[SLOT_VERDICT];
   assign path_ok     = head[SLOT_VERDICT] && ok_ff;

   always_comb begin
      if (head[SLOT_SEP]) begin
         out_char = CHR_SLASH;
      end else if (head[SLOT_DOT1] || head[SLOT_DOT2]) begin
         out_char = CHR_DOT;
      end else if (head[SLOT_BYTE]) begin
         out_char = byte_ff;
      end else begin
         out_char = CHR_NONE;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (fire) begin
         mask_in = rest;
      end
      if (load) begin
         mask_in = burst.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= burst.byte_val;
         ok_ff   <= burst.path_ok;
      end
   end

`ifndef ASSERT_OFF
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("burst loaded over pending results");
   a_drain_continues : assert property (@(posedge clock) disable iff (reset)
      (fire && (rest != '0) && !load) |=> out_valid)
      else $error("pending results lost while draining");
   a_dots_in_order : assert property (@(posedge clock) disable iff (reset)
      load |=> !(mask_ff[SLOT_DOT2] && !mask_ff[SLOT_DOT1]))
      else $error("second held dot without first");
   a_verdict_last : assert property (@(posedge clock) disable iff (reset)
      (out_valid && end_of_path) |-> (rest == '0))
      else $error("verdict is not the final result of its burst");
`endif

endmodule

>>> rtl/core/repo_path_normalizer.sv
// Channel  Dir  tdata                          tuser       tlast
// req      in   [7:0] path byte                has_char    last beat of path
// rsp      out  [7:0] out byte, [8] path_ok    is_char     verdict beat
//
// One path byte is taken per beat and a beat may be accepted in every cycle.
// Each accepted beat yields zero to five result beats, drained one per cycle
// while rsp_tready is high; a beat with more than one result stalls req
// until its last result leaves. The synchronous reset clears the path state
// and the pending results. req is accepted when no result is pending or while
// the last pending result of the previous beat leaves.
module repo_path_normalizer
   import rpn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] chr
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [8] path_ok, [15:9] zero
   output logic        rsp_tuser,   // [0] is_char
   output logic        rsp_tlast
);

   logic      accept;
   burst_type burst;
   logic [7:0] out_char;
   logic       path_ok;

   // A beat is taken when the result register is free or frees this cycle.
   assign accept = req_tvalid && req_tready;

   // The step unit holds the per-path state and works out the burst.
   rpn_step u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .chr      (req_tdata),
      .has_char (req_tuser),
      .last     (req_tlast),
      .burst    (burst)
   );

   // The burst register holds one beat's results and sends them in order.
   rpn_burst u_burst (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .burst       (burst),
      .can_load    (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_char    (out_char),
      .is_char     (rsp_tuser),
      .path_ok     (path_ok),
      .end_of_path (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, path_ok, out_char};

endmodule

>>> test/rpn_checker.sv
module rpn_checker
   import rpn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] chr
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] out_char, [8] path_ok, [15:9] zero
   input  logic        rsp_tuser,   // [0] is_char
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_char;
      logic       path_ok;
      logic       end_of_path;
   } norm_result_type;

   norm_result_type norm_results_q[$];
   int              bad_count;

   // Running state of the path being normalized.
   logic       seen_any;
   logic       sep_owed;
   logic       inside_comp;
   logic       dots_only;
   logic [1:0] dots_held;
   logic       last_was_sep;
   logic       rejected;

   task automatic restart_path();
      seen_any     = 1'b0;
      sep_owed     = 1'b0;
      inside_comp  = 1'b0;
      dots_only    = 1'b1;
      dots_held    = 2'd0;
      last_was_sep = 1'b0;
      rejected     = 1'b0;
   endtask

   // Appends one expected result beat behind those already owed.
   task automatic expect_beat(input norm_result_type r);
      norm_results_q.insert(norm_results_q.size(), r);
   endtask

   task automatic push_char(input logic [7:0] c);
      expect_beat(norm_result_type'{c, 1'b1, 1'b0, 1'b0});
   endtask

   // Works out the result beats that one accepted request beat causes.
   task automatic normalize_beat(input logic [7:0] c, input logic has, input logic last);
      logic is_sep;
      logic ok;
      is_sep = (c == CHR_SLASH) || (c == CHR_BSLASH);
      if (has) begin
         if (rejected) begin
            // Bytes after a rejection are swallowed.
         end else if (c < CHR_SPACE || c == CHR_DEL || c == CHR_COLON) begin
            rejected = 1'b1;
         end else if (is_sep) begin
            if (!seen_any) begin
               rejected = 1'b1;
            end else if (inside_comp) begin
               if (dots_only && dots_held != 2'd0) begin
                  rejected = 1'b1;
               end else begin
                  inside_comp = 1'b0;
                  sep_owed    = 1'b1;
               end
            end
            last_was_sep = 1'b1;
         end else begin
            if (!inside_comp) begin
               inside_comp = 1'b1;
               dots_only   = 1'b1;
               dots_held   = 2'd0;
            end
            if (dots_only) begin
               if (c == CHR_DOT && dots_held < MAX_HELD_DOTS) begin
                  dots_held++;
               end else begin
                  if (sep_owed) begin
                     push_char(CHR_SLASH);
                     sep_owed = 1'b0;
                  end
                  repeat (dots_held) push_char(CHR_DOT);
                  dots_held = 2'd0;
                  dots_only = 1'b0;
                  push_char(c);
               end
            end else begin
               push_char(c);
            end
            last_was_sep = 1'b0;
         end
         seen_any = 1'b1;
      end
      if (last) begin
         ok = !rejected && seen_any && !last_was_sep && inside_comp &&
              !(dots_only && dots_held != 2'd0);
         expect_beat(norm_result_type'{CHR_NONE, 1'b0, ok, 1'b1});
         restart_path();
      end
   endtask

   always @(posedge clock) begin : watch
      norm_result_type want;
      if (reset) begin
         restart_path();
         norm_results_q.delete();
         bad_count = 0;
      end else begin
         // Predict first so that a result leaving in the same cycle still
         // finds its expectation in order.
         if (req_tvalid && req_tready) begin
            normalize_beat(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (norm_results_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10) begin
                  $display("checker: unexpected result beat tdata=%h tuser=%b tlast=%b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end else begin
               want = norm_results_q.pop_front();
               if (rsp_tdata !== {7'd0, want.path_ok, want.out_char} ||
                   rsp_tuser !== want.is_char || rsp_tlast !== want.end_of_path) begin
                  bad_count++;
                  if (bad_count <= 10) begin
                     $display("checker: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b pad %h",
                              want.out_char, want.is_char, want.path_ok,
                              want.end_of_path, rsp_tdata[7:0], rsp_tuser,
                              rsp_tdata[8], rsp_tlast, rsp_tdata[15:9]);
                  end
               end
            end
         end
      end
      mismatches   <= bad_count;
      results_owed <= norm_results_q.size();
   end

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   // One request beat as the generator builds it.
   typedef struct packed {
      logic [7:0] chr;
      logic       has_char;
      logic       last;
   } path_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] chr
   logic        req_tuser  = 1'b0;   // [0] has_char
   logic        req_tlast  = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire [15:0]  rsp_tdata;           // [7:0] out_char, [8] path_ok, [15:9] zero
   wire         rsp_tuser;           // [0] is_char
   wire         rsp_tlast;

   int mismatches;
   int results_owed;

   // Percent of cycles in which each side holds off. The main sequence
   // changes these between phases.
   int send_idle_pct = 12;
   int recv_idle_pct = 72;

   // Beats that carry a byte or end a path; empty filler beats do not count.
   int beats_sent = 0;

   always #2 clock = ~clock;

   repo_path_normalizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rpn_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   // The receiver decides afresh in every cycle whether to take a result.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offers one beat and returns at the edge where it is taken. A random
   // hold-off may come first; valid is only lowered for a real gap, so back
   // to back beats keep it high without a second assignment in one step.
   task automatic send_beat(input logic [7:0] c, input logic has, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= has;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has || last) beats_sent++;
   endtask

   // Sends a whole path written as text, marking its final byte.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(s[i], 1'b1, i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] pick_sep();
      return ($urandom_range(1) != 0) ? CHR_SLASH : CHR_BSLASH;
   endfunction

   // A byte for the body of a component. Mostly legal name bytes, with some
   // dots, some fully random bytes and now and then a forbidden one.
   function automatic logic [7:0] name_byte();
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         case ($urandom_range(2))
            0:       return 8'($urandom_range(8'h1F, 8'h00));
            1:       return CHR_DEL;
            default: return CHR_COLON;
         endcase
      end else if (r < 8) begin
         return CHR_DOT;
      end else if (r < 20) begin
         return 8'($urandom_range(8'hFF, 8'h00));
      end else if (r < 70) begin
         return 8'($urandom_range("z", "a"));
      end
      return 8'($urandom_range(8'hFF, 8'h80));
   endfunction

   // Builds one random path and sends it. Most paths are well formed, with
   // runs of mixed separators and dot components of one to four dots; a share
   // start or end with a separator, hold a bad byte, or are empty.
   task automatic send_random_path();
      path_beat_type beats[$];
      path_beat_type tail;
      int            shape;
      int            n_comp;
      int            style;
      int            dots;
      int            letters;
      shape = $urandom_range(99);
      if (shape < 5) begin
         send_beat(8'($urandom), 1'b0, 1'b1);
      end else begin
         if (shape < 10) begin
            beats.insert(beats.size(), path_beat_type'{pick_sep(), 1'b1, 1'b0});
         end
         n_comp = $urandom_range(4, 1);
         for (int i = 0; i < n_comp; i++) begin
            if (i > 0) begin
               repeat ($urandom_range(3, 1)) begin
                  beats.insert(beats.size(), path_beat_type'{pick_sep(), 1'b1, 1'b0});
               end
            end
            style = $urandom_range(99);
            if (style < 5) begin
               dots    = 1;
               letters = 0;
            end else if (style < 10) begin
               dots    = 2;
               letters = 0;
            end else if (style < 20) begin
               dots    = $urandom_range(4, 3);
               letters = $urandom_range(2, 0);
            end else if (style < 35) begin
               dots    = $urandom_range(2, 1);
               letters = $urandom_range(4, 1);
            end else begin
               dots    = 0;
               letters = $urandom_range(5, 1);
            end
            repeat (dots) begin
               beats.insert(beats.size(), path_beat_type'{CHR_DOT, 1'b1, 1'b0});
            end
            repeat (letters) begin
               beats.insert(beats.size(), path_beat_type'{name_byte(), 1'b1, 1'b0});
            end
         end
         if (shape >= 10 && shape < 15) begin
            beats.insert(beats.size(), path_beat_type'{pick_sep(), 1'b1, 1'b0});
         end
         // The path ends either on its final byte or on a byteless last beat.
         if ($urandom_range(9) == 0) begin
            beats.insert(beats.size(), path_beat_type'{8'($urandom), 1'b0, 1'b1});
         end else begin
            tail      = beats.pop_back();
            tail.last = 1'b1;
            beats.insert(beats.size(), tail);
         end
         foreach (beats[i]) begin
            // Byteless beats inside a path must leave it unchanged.
            if ($urandom_range(99) < 4) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(beats[i].chr, beats[i].has_char, beats[i].last);
         end
      end
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed paths: empty path, extreme bytes, mixed separators, the
      // full five-beat burst, three dots turning ordinary, leading and
      // trailing separators, forbidden bytes, a dot-only component at the
      // end, and a byteless beat in the middle of a path.
      send_beat(CHR_NONE, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_text(" \\/b");
      send_text("a/..x");
      send_text("...");
      send_text("/a");
      send_text("a:");
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(CHR_DEL, 1'b1, 1'b1);
      send_text("a/");
      send_text("..");
      send_beat("a", 1'b1, 1'b0);
      send_beat(CHR_NONE, 1'b0, 1'b0);
      send_beat("b", 1'b1, 1'b1);

      // Random paths in three phases of backpressure: a slow receiver, then
      // a slow sender, then both at full rate.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = beats_sent;
         while (beats_sent - phase_start < 100) send_random_path();
      end
      req_tvalid <= 1'b0;

      // Drain every owed result, then give the block time to show any
      // stray beat before the verdict.
      while (results_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && results_owed == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_step.sv
rtl/core/rpn_burst.sv
rtl/core/repo_path_normalizer.sv
test/rpn_checker.sv
test/tb.sv
